>>> rtl/lrq_pkg.sv
package lrq_pkg;

	localparam int FRAC_BITS = 14;

	// Unit latencies, one register per result bit.
	localparam int SQRT_LAT = 32;
	localparam int DIV_LAT  = 32;
	localparam int NORM_LAT = 5 + SQRT_LAT + 1 + DIV_LAT + 1;
	localparam int PIPE_LAT = 1 + NORM_LAT + 2 + NORM_LAT + 2 + 1 + SQRT_LAT + 1 + DIV_LAT + 1;

	localparam int OUT_SH = 30 - FRAC_BITS;
	localparam logic [33:0] OUT_RND = (OUT_SH > 0) ? (34'd1 << (OUT_SH - 1)) : 34'd0;

	localparam logic [1:0] CFG_UP_X = 2'd0;
	localparam logic [1:0] CFG_UP_Y = 2'd1;
	localparam logic [1:0] CFG_UP_Z = 2'd2;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [31:0] unit_t;
	typedef logic signed [15:0] qout_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec32_t;

	typedef struct packed {
		logic [3:0] half;
		logic [3:0] neg;
		logic       degen;
	} slot_ctl_t;

	// Round half away from zero to FRAC_BITS, then saturate.
	function automatic qout_t to_out(input logic [32:0] mag, input logic neg, input logic ovf);
		logic [33:0] mr;
		logic [16:0] ms;
		qout_t       res;
		mr = ({1'b0, mag} + OUT_RND) >> OUT_SH;
		if (ovf || mr > 34'd32768) begin
			ms = 17'd32768;
		end else begin
			ms = mr[16:0];
		end
		if (neg) begin
			res = qout_t'(-$signed({1'b0, ms}));
		end else if (ms[15] || ms[16]) begin
			res = 16'sh7fff;
		end else begin
			res = qout_t'(ms);
		end
		return res;
	endfunction

	localparam qout_t ID_W = to_out(33'd1 << 30, 1'b0, 1'b0);

endpackage

>>> rtl/look_rotation_quaternion_core.sv
// Look-rotation quaternion: each item is a forward vector (Q16.16); with the configured
// up vector the core builds an orthonormal basis and returns the rotation as a Q2.14
// quaternion. A zero forward vector, or an up vector exactly parallel to it, gives the
// identity with degenerate set. Fully pipelined: one item per cycle while the output
// is not stalled, passing through the two vector normalisers (leading-one
// shift, squares, a 32-stage square root and 32-stage dividers each) followed by the
// quaternion square root and dividers. An output stall freezes the whole pipeline.
// Write up_x/up_y/up_z only while no item is in flight; cfg_ready is always high.
module look_rotation_quaternion_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  fwd_valid,
	output logic                  fwd_stall,
	input  lrq_pkg::q16_t         fwd_x,
	input  lrq_pkg::q16_t         fwd_y,
	input  lrq_pkg::q16_t         fwd_z,
	output logic                  quat_valid,
	input  logic                  quat_stall,
	output lrq_pkg::qout_t        quat_x,
	output lrq_pkg::qout_t        quat_y,
	output lrq_pkg::qout_t        quat_z,
	output lrq_pkg::qout_t        quat_w,
	output logic                  degenerate
);

	localparam int NL = lrq_pkg::NORM_LAT;
	localparam logic signed [35:0] ONE30 = 36'sd1073741824;

	logic adv;
	logic vld_q [lrq_pkg::PIPE_LAT];

	lrq_pkg::vec32_t up_q;

	lrq_pkg::vec32_t f_s1, u_s1;
	lrq_pkg::vec32_t u_dly_q [NL];

	lrq_pkg::unit_t r2x, r2y, r2z, r0x, r0y, r0z;
	logic           zero1, zero2;

	logic signed [5:0][63:0] cp_s2;
	lrq_pkg::vec32_t         r2_s2, r2_s3;
	logic                    z1_s2, z1_s3;
	logic signed [63:0]      cx_s3, cy_s3, cz_s3;
	lrq_pkg::vec32_t         r2_dly_q [NL];
	logic                    z1_dly_q [NL];

	logic signed [5:0][63:0] rp_s4;
	lrq_pkg::vec32_t         r0_s4, r2_s4, r0_s5, r2_s5;
	logic                    z_s4, z_s5;
	logic signed [33:0]      r1x_s5, r1y_s5, r1z_s5;

	logic signed [35:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, arg;
	logic signed [35:0] dsl [4];
	logic [3:0]         half_c;
	logic [63:0]        rad_s6;
	logic [3:0][33:0]   dmag_s6;
	lrq_pkg::slot_ctl_t ctl_s6;
	logic [3:0][33:0]   dmag_dly_q [lrq_pkg::SQRT_LAT];
	lrq_pkg::slot_ctl_t ctl_dly_q  [lrq_pkg::SQRT_LAT];
	logic [31:0]        root;

	logic [3:0][63:0]   num_s7;
	logic [33:0]        den_s7;
	logic [31:0]        s_s7;
	logic [3:0]         ovf_s7;
	lrq_pkg::slot_ctl_t ctl_s7;
	logic [31:0]        s_dly_q   [lrq_pkg::DIV_LAT];
	logic [3:0]         ovf_dly_q [lrq_pkg::DIV_LAT];
	lrq_pkg::slot_ctl_t ctl2_dly_q [lrq_pkg::DIV_LAT];
	logic [3:0][31:0]   quo;

	lrq_pkg::qout_t qs_s8 [4];
	logic           degen_s8;

	assign adv       = !(vld_q[lrq_pkg::PIPE_LAT-1] && quat_stall);
	assign fwd_stall = !adv;
	assign cfg_ready = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= '{x: 32'sd0, y: 32'sd65536, z: 32'sd0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lrq_pkg::CFG_UP_X: up_q.x <= cfg_data;
				lrq_pkg::CFG_UP_Y: up_q.y <= cfg_data;
				lrq_pkg::CFG_UP_Z: up_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lrq_pkg::PIPE_LAT; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= fwd_valid;
			for (int k = 1; k < lrq_pkg::PIPE_LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// branch choice and numerators for the matrix to quaternion step
	always_comb begin
		m00 = 36'(r0_s5.x);  m01 = 36'(r0_s5.y);  m02 = 36'(r0_s5.z);
		m10 = 36'(r1x_s5);   m11 = 36'(r1y_s5);   m12 = 36'(r1z_s5);
		m20 = 36'(r2_s5.x);  m21 = 36'(r2_s5.y);  m22 = 36'(r2_s5.z);
		tr  = m00 + m11 + m22;
		priority if (tr > 36'sd0) begin
			arg = tr + ONE30;
			dsl[0] = m12 - m21; dsl[1] = m20 - m02; dsl[2] = m01 - m10; dsl[3] = '0;
			half_c = 4'b1000;
		end else if (m00 >= m11 && m00 >= m22) begin
			arg = ONE30 + m00 - m11 - m22;
			dsl[0] = '0; dsl[1] = m01 + m10; dsl[2] = m02 + m20; dsl[3] = m12 - m21;
			half_c = 4'b0001;
		end else if (m11 > m22) begin
			arg = ONE30 + m11 - m00 - m22;
			dsl[0] = m10 + m01; dsl[1] = '0; dsl[2] = m21 + m12; dsl[3] = m20 - m02;
			half_c = 4'b0010;
		end else begin
			arg = ONE30 + m22 - m00 - m11;
			dsl[0] = m20 + m02; dsl[1] = m21 + m12; dsl[2] = '0; dsl[3] = m01 - m10;
			half_c = 4'b0100;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1 <= '{x: fwd_x, y: fwd_y, z: fwd_z};
			u_s1 <= up_q;

			u_dly_q[0] <= u_s1;
			for (int k = 1; k < NL; k++) u_dly_q[k] <= u_dly_q[k-1];

			// up x forward
			cp_s2[0] <= u_dly_q[NL-1].y * r2z;
			cp_s2[1] <= u_dly_q[NL-1].z * r2y;
			cp_s2[2] <= u_dly_q[NL-1].z * r2x;
			cp_s2[3] <= u_dly_q[NL-1].x * r2z;
			cp_s2[4] <= u_dly_q[NL-1].x * r2y;
			cp_s2[5] <= u_dly_q[NL-1].y * r2x;
			r2_s2    <= '{x: r2x, y: r2y, z: r2z};
			z1_s2    <= zero1;

			cx_s3 <= cp_s2[0] - cp_s2[1];
			cy_s3 <= cp_s2[2] - cp_s2[3];
			cz_s3 <= cp_s2[4] - cp_s2[5];
			r2_s3 <= r2_s2;
			z1_s3 <= z1_s2;

			r2_dly_q[0] <= r2_s3;
			z1_dly_q[0] <= z1_s3;
			for (int k = 1; k < NL; k++) begin
				r2_dly_q[k] <= r2_dly_q[k-1];
				z1_dly_q[k] <= z1_dly_q[k-1];
			end

			// forward x row 0
			rp_s4[0] <= r2_dly_q[NL-1].y * r0z;
			rp_s4[1] <= r2_dly_q[NL-1].z * r0y;
			rp_s4[2] <= r2_dly_q[NL-1].z * r0x;
			rp_s4[3] <= r2_dly_q[NL-1].x * r0z;
			rp_s4[4] <= r2_dly_q[NL-1].x * r0y;
			rp_s4[5] <= r2_dly_q[NL-1].y * r0x;
			r0_s4    <= '{x: r0x, y: r0y, z: r0z};
			r2_s4    <= r2_dly_q[NL-1];
			z_s4     <= z1_dly_q[NL-1] || zero2;

			// arithmetic shift is the floor division by 2^30
			r1x_s5 <= 34'(rp_s4[0] >>> 30) - 34'(rp_s4[1] >>> 30);
			r1y_s5 <= 34'(rp_s4[2] >>> 30) - 34'(rp_s4[3] >>> 30);
			r1z_s5 <= 34'(rp_s4[4] >>> 30) - 34'(rp_s4[5] >>> 30);
			r0_s5  <= r0_s4;
			r2_s5  <= r2_s4;
			z_s5   <= z_s4;

			rad_s6 <= (arg < 36'sd1) ? (64'd1 << 30) : {arg[33:0], 30'd0};
			for (int i = 0; i < 4; i++) begin
				dmag_s6[i]    <= dsl[i][35] ? 34'(-dsl[i]) : 34'(dsl[i]);
				ctl_s6.neg[i] <= dsl[i][35];
			end
			ctl_s6.half  <= half_c;
			ctl_s6.degen <= z_s5;

			dmag_dly_q[0] <= dmag_s6;
			ctl_dly_q[0]  <= ctl_s6;
			for (int k = 1; k < lrq_pkg::SQRT_LAT; k++) begin
				dmag_dly_q[k] <= dmag_dly_q[k-1];
				ctl_dly_q[k]  <= ctl_dly_q[k-1];
			end

			// quotient of 2^32 or more saturates anyway: flag it, divide zero
			den_s7 <= {1'b0, root, 1'b0};
			s_s7   <= root;
			ctl_s7 <= ctl_dly_q[lrq_pkg::SQRT_LAT-1];
			for (int i = 0; i < 4; i++) begin
				if (({2'b00, dmag_dly_q[lrq_pkg::SQRT_LAT-1][i][33:2]}) >=
					{1'b0, root, 1'b0}) begin
					ovf_s7[i] <= 1'b1;
					num_s7[i] <= '0;
				end else begin
					ovf_s7[i] <= 1'b0;
					num_s7[i] <= {dmag_dly_q[lrq_pkg::SQRT_LAT-1][i], 30'd0};
				end
			end

			s_dly_q[0]    <= s_s7;
			ovf_dly_q[0]  <= ovf_s7;
			ctl2_dly_q[0] <= ctl_s7;
			for (int k = 1; k < lrq_pkg::DIV_LAT; k++) begin
				s_dly_q[k]    <= s_dly_q[k-1];
				ovf_dly_q[k]  <= ovf_dly_q[k-1];
				ctl2_dly_q[k] <= ctl2_dly_q[k-1];
			end

			degen_s8 <= ctl2_dly_q[lrq_pkg::DIV_LAT-1].degen;
			for (int i = 0; i < 4; i++) begin
				if (ctl2_dly_q[lrq_pkg::DIV_LAT-1].degen) begin
					qs_s8[i] <= (i == 3) ? lrq_pkg::ID_W : '0;
				end else if (ctl2_dly_q[lrq_pkg::DIV_LAT-1].half[i]) begin
					qs_s8[i] <= lrq_pkg::to_out({2'b00, s_dly_q[lrq_pkg::DIV_LAT-1][31:1]},
						1'b0, 1'b0);
				end else begin
					qs_s8[i] <= lrq_pkg::to_out({1'b0, quo[i]},
						ctl2_dly_q[lrq_pkg::DIV_LAT-1].neg[i],
						ovf_dly_q[lrq_pkg::DIV_LAT-1][i]);
				end
			end
		end
	end

	lrq_norm u_norm_fwd (
		.clk    (clk),
		.en     (adv),
		.vec_x  (64'(f_s1.x)),
		.vec_y  (64'(f_s1.y)),
		.vec_z  (64'(f_s1.z)),
		.unit_x (r2x),
		.unit_y (r2y),
		.unit_z (r2z),
		.zero   (zero1)
	);

	lrq_norm u_norm_side (
		.clk    (clk),
		.en     (adv),
		.vec_x  (cx_s3),
		.vec_y  (cy_s3),
		.vec_z  (cz_s3),
		.unit_x (r0x),
		.unit_y (r0y),
		.unit_z (r0z),
		.zero   (zero2)
	);

	lrq_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s6),
		.root (root)
	);

	for (genvar i = 0; i < 4; i++) begin : g_div
		lrq_div u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s7[i]),
			.den (den_s7),
			.quo (quo[i])
		);
	end

	assign quat_valid = vld_q[lrq_pkg::PIPE_LAT-1];
	assign quat_x     = qs_s8[0];
	assign quat_y     = qs_s8[1];
	assign quat_z     = qs_s8[2];
	assign quat_w     = qs_s8[3];
	assign degenerate = degen_s8;

`ifndef SYNTHESIS
	a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_stall |-> quat_valid)
		else $error("input stalled with no result waiting");

	a_degen_xyz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && degenerate |-> quat_x == 16'sd0 && quat_y == 16'sd0 && quat_z == 16'sd0)
		else $error("degenerate item with non-zero vector part");

	a_degen_w_one: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && degenerate |-> quat_w == lrq_pkg::ID_W)
		else $error("degenerate item with wrong w");
`endif

endmodule

>>> rtl/lrq_sqrt.sv
module lrq_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [33:0] rem_s  [lrq_pkg::SQRT_LAT];
	logic [31:0] root_s [lrq_pkg::SQRT_LAT];
	logic [63:0] rest_s [lrq_pkg::SQRT_LAT];

	for (genvar k = 0; k < lrq_pkg::SQRT_LAT; k++) begin : g_stage
		logic [31:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] rest_in;
		logic [33:0] cur;
		logic [33:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rest_in = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1][31:0];
			assign root_in = root_s[k-1];
			assign rest_in = rest_s[k-1];
		end

		// two radicand bits in, one root bit out
		assign cur   = {rem_in, rest_in[63:62]};
		assign trial = {root_in, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (cur - trial) : cur;
				root_s[k] <= {root_in[30:0], ge};
				rest_s[k] <= {rest_in[61:0], 2'b00};
			end
		end
	end

	assign root = root_s[lrq_pkg::SQRT_LAT-1];

endmodule

>>> rtl/lrq_div.sv
module lrq_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [33:0] den,
	output logic [31:0] quo
);

	// expects num[63:32] < den, so the quotient fits in 32 bits
	logic [33:0] rem_s  [lrq_pkg::DIV_LAT];
	logic [31:0] rest_s [lrq_pkg::DIV_LAT];
	logic [31:0] quo_s  [lrq_pkg::DIV_LAT];
	logic [33:0] den_s  [lrq_pkg::DIV_LAT];

	for (genvar k = 0; k < lrq_pkg::DIV_LAT; k++) begin : g_stage
		logic [33:0] rem_in;
		logic [31:0] rest_in;
		logic [31:0] quo_in;
		logic [33:0] den_in;
		logic [34:0] cur;
		logic [34:0] diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in  = {2'b00, num[63:32]};
			assign rest_in = num[31:0];
			assign quo_in  = '0;
			assign den_in  = den;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign rest_in = rest_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign den_in  = den_s[k-1];
		end

		assign cur  = {rem_in, rest_in[31]};
		assign diff = cur - {1'b0, den_in};
		assign ge   = (cur >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[33:0] : cur[33:0];
				rest_s[k] <= {rest_in[30:0], 1'b0};
				quo_s[k]  <= {quo_in[30:0], ge};
				den_s[k]  <= den_in;
			end
		end
	end

	assign quo = quo_s[lrq_pkg::DIV_LAT-1];

endmodule

>>> rtl/lrq_norm.sv
module lrq_norm (
	input  logic                clk,
	input  logic                en,
	input  logic signed [63:0]  vec_x,
	input  logic signed [63:0]  vec_y,
	input  logic signed [63:0]  vec_z,
	output lrq_pkg::unit_t      unit_x,
	output lrq_pkg::unit_t      unit_y,
	output lrq_pkg::unit_t      unit_z,
	output logic                zero
);

	localparam int SIDE_LAT = lrq_pkg::SQRT_LAT + 1 + lrq_pkg::DIV_LAT;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} side_t;

	function automatic logic [5:0] lead_pos(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	logic [2:0][63:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [2:0][63:0] mag_s2;
	logic [5:0]       pos_s2;
	side_t            side_s2, side_s3, side_s4, side_s5;
	logic [2:0][30:0] nm_s3, nm_s4, nm_s5;
	logic [2:0][61:0] sq_s4;
	logic [63:0]      len2_s5;
	logic [2:0][30:0] nm_dly_q   [lrq_pkg::SQRT_LAT];
	side_t            side_dly_q [SIDE_LAT];
	logic [31:0]      len;
	logic [2:0][63:0] num_s6;
	logic [33:0]      den_s6;
	logic [2:0][31:0] quo;
	lrq_pkg::unit_t   ux_s7, uy_s7, uz_s7;
	logic             zero_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1[0] <= vec_x[63] ? 64'(-vec_x) : 64'(vec_x);
			mag_s1[1] <= vec_y[63] ? 64'(-vec_y) : 64'(vec_y);
			mag_s1[2] <= vec_z[63] ? 64'(-vec_z) : 64'(vec_z);
			neg_s1    <= {vec_z[63], vec_y[63], vec_x[63]};

			// largest magnitude shares its leading one with the OR of all three
			mag_s2       <= mag_s1;
			pos_s2       <= lead_pos(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			side_s2.neg  <= neg_s1;
			side_s2.zero <= ((mag_s1[0] | mag_s1[1] | mag_s1[2]) == 64'd0);

			for (int i = 0; i < 3; i++) begin
				if (pos_s2 > 6'd30) begin
					nm_s3[i] <= 31'(mag_s2[i] >> (pos_s2 - 6'd30));
				end else begin
					nm_s3[i] <= 31'(mag_s2[i] << (6'd30 - pos_s2));
				end
			end
			side_s3 <= side_s2;

			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= 62'(nm_s3[i]) * 62'(nm_s3[i]);
			end
			nm_s4   <= nm_s3;
			side_s4 <= side_s3;

			len2_s5 <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			nm_s5   <= nm_s4;
			side_s5 <= side_s4;

			nm_dly_q[0]   <= nm_s5;
			side_dly_q[0] <= side_s5;
			for (int k = 1; k < lrq_pkg::SQRT_LAT; k++) nm_dly_q[k] <= nm_dly_q[k-1];
			for (int k = 1; k < SIDE_LAT; k++) side_dly_q[k] <= side_dly_q[k-1];

			for (int i = 0; i < 3; i++) begin
				num_s6[i] <= {3'b000, nm_dly_q[lrq_pkg::SQRT_LAT-1][i], 30'd0};
			end
			den_s6 <= {2'b00, len};

			ux_s7   <= side_dly_q[SIDE_LAT-1].neg[0] ? -$signed(quo[0]) : $signed(quo[0]);
			uy_s7   <= side_dly_q[SIDE_LAT-1].neg[1] ? -$signed(quo[1]) : $signed(quo[1]);
			uz_s7   <= side_dly_q[SIDE_LAT-1].neg[2] ? -$signed(quo[2]) : $signed(quo[2]);
			zero_s7 <= side_dly_q[SIDE_LAT-1].zero;
		end
	end

	lrq_sqrt u_len (
		.clk  (clk),
		.en   (en),
		.rad  (len2_s5),
		.root (len)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		lrq_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s6[i]),
			.den (den_s6),
			.quo (quo[i])
		);
	end

	assign unit_x = ux_s7;
	assign unit_y = uy_s7;
	assign unit_z = uz_s7;
	assign zero   = zero_s7;

endmodule
